### rtl/b64d_pkg.sv
// Shared types, constants and the character-to-sextet mapping of the stream decoder.
package b64d_pkg;

    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_AW    = 3;
    localparam int unsigned FIFO_CW    = 4;
    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    typedef struct packed {
        logic       halted_flag;
        logic       message_end;
        logic       run_end;
        logic       byte_valid;
        logic [7:0] out_byte;
    } result_t;

    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     res;
    } bundle_t;

    // Bit 6 is the valid flag, bits 5..0 the sextet value.
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [6:0] v;
        v = 7'd0;
        case (ch) inside
            [8'h41:8'h5A]: v = {1'b1, 6'(ch - 8'd65)};
            [8'h61:8'h7A]: v = {1'b1, 6'(ch - 8'd71)};
            [8'h30:8'h39]: v = {1'b1, 6'(ch + 8'd4)};
            8'h2B:         v = {1'b1, SEXTET_PLUS};
            8'h2F:         v = {1'b1, SEXTET_SLASH};
            default:       v = 7'd0;
        endcase
        return v;
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_CR) || (ch == CHAR_LF);
    endfunction

endpackage

### rtl/b64d_decode.sv
// Group state and single-pass decoding of one character into up to three results.
module b64d_decode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [7:0]           in_char,
    input  logic                 in_last,
    output b64d_pkg::bundle_t    bundle
);

    logic [1:0] pos_reg, pos_next;
    logic       halted_reg, halted_next;
    logic [6:0] st0_reg, st1_reg, st2_reg;

    logic [6:0] sx, s0, s1, s2, s3;
    logic       process, group_go, ok;
    logic [1:0] nb, nres;
    logic [7:0] b0, b1, b2;
    logic [7:0] bytes [3];

    always_comb begin
        sx       = b64d_pkg::sextet_of(in_char);
        process  = !halted_reg && !(pos_reg == 2'd0 && b64d_pkg::is_space(in_char));
        s0       = st0_reg;
        s1       = st1_reg;
        s2       = st2_reg;
        s3       = sx;
        group_go = 1'b0;
        pos_next = pos_reg;
        if (process) begin
            if (pos_reg == 2'd3) begin
                group_go = 1'b1;
                pos_next = 2'd0;
            end else begin
                pos_next = pos_reg + 2'd1;
                if (in_last) begin
                    group_go = 1'b1;
                    s3 = 7'd0;
                    case (pos_reg)
                        2'd0: begin
                            s0 = sx;
                            s1 = 7'd0;
                            s2 = 7'd0;
                        end
                        2'd1: begin
                            s1 = sx;
                            s2 = 7'd0;
                        end
                        default: begin
                            s2 = sx;
                        end
                    endcase
                end
            end
        end

        ok          = s0[6] && s1[6];
        halted_next = halted_reg || (group_go && !ok);
        if (group_go && ok) begin
            nb = s2[6] ? (s3[6] ? 2'd3 : 2'd2) : 2'd1;
        end else begin
            nb = 2'd0;
        end
        nres = (in_last && nb == 2'd0) ? 2'd1 : nb;

        b0 = {s0[5:0], s1[5:4]};
        b1 = {s1[3:0], s2[5:2]};
        b2 = {s2[1:0], s3[5:0]};
        bytes[0] = b0;
        bytes[1] = b1;
        bytes[2] = b2;

        for (int k = 0; k < 3; k++) begin
            bundle.res[k].byte_valid  = 2'(k) < nb;
            bundle.res[k].out_byte    = (2'(k) < nb) ? bytes[k] : 8'd0;
            bundle.res[k].run_end     = 2'(k) == (nres - 2'd1);
            bundle.res[k].message_end = in_last && (2'(k) == (nres - 2'd1));
            bundle.res[k].halted_flag = halted_next;
        end
        bundle.count = in_valid ? nres : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= 2'd0;
            halted_reg <= 1'b0;
        end else if (in_valid) begin
            if (in_last) begin
                pos_reg    <= 2'd0;
                halted_reg <= 1'b0;
            end else begin
                pos_reg    <= pos_next;
                halted_reg <= halted_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && process) begin
            case (pos_reg)
                2'd0:    st0_reg <= sx;
                2'd1:    st1_reg <= sx;
                2'd2:    st2_reg <= sx;
                default: st2_reg <= st2_reg;
            endcase
        end
    end

endmodule

### rtl/b64d_out_fifo.sv
// Result queue that takes up to three results per cycle and hands out one per cycle when popped.
module b64d_out_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  b64d_pkg::bundle_t    push,
    input  logic                 pop,
    output b64d_pkg::result_t    head,
    output logic                 not_empty,
    output logic                 has_room
);

    b64d_pkg::result_t mem [b64d_pkg::FIFO_DEPTH];

    logic [b64d_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [b64d_pkg::FIFO_CW-1:0] count_reg, count_next;

    always_comb begin
        count_next = count_reg + b64d_pkg::FIFO_CW'(push.count)
                     - b64d_pkg::FIFO_CW'(pop);
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign has_room  = count_reg <=
                       b64d_pkg::FIFO_CW'(b64d_pkg::FIFO_DEPTH - b64d_pkg::MAX_RESULTS);

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < push.count) begin
                mem[b64d_pkg::FIFO_AW'(wr_ptr_reg + b64d_pkg::FIFO_AW'(k))] <= push.res[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + b64d_pkg::FIFO_AW'(push.count);
            rd_ptr_reg <= rd_ptr_reg + b64d_pkg::FIFO_AW'(pop);
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/base64_stream_decoder.sv
// Top level of the streaming Base64 decoder: character decoding and result queue.
//
//  Channel  Direction  Item content
//  s_       in         tdata[7:0] character, tlast end of message
//  m_       out        tdata[7:0] byte, [8] run end, [9] halted; tuser byte valid; tlast message end
//
// One character is accepted per cycle while s_tready is high; its results
// enter the queue at the accepting edge and leave one per cycle while
// m_tready is high. The eight-entry result queue sets input backpressure:
// s_tready drops while fewer than three entries are free.
// Reset is synchronous and returns the group state and the queue to empty.
module base64_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] run_end, [9] halted_flag, zero fill
    output logic [0:0]  m_tuser,   // [0] byte_valid
    output logic        m_tlast    // message_end
);

    b64d_pkg::bundle_t bundle;
    b64d_pkg::result_t head;
    logic              accept;

    assign accept = s_tvalid && s_tready;

    b64d_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (accept),
        .in_char  (s_tdata),
        .in_last  (s_tlast),
        .bundle   (bundle)
    );

    b64d_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (bundle),
        .pop       (m_tvalid && m_tready),
        .head      (head),
        .not_empty (m_tvalid),
        .has_room  (s_tready)
    );

    assign m_tdata = {6'd0, head.halted_flag, head.run_end, head.out_byte};
    assign m_tuser = head.byte_valid;
    assign m_tlast = head.message_end;

endmodule

### rtl/b64d_checker.sv
// Port-level checks of the stream decoder, bound to the top level.
module b64d_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    a_msg_end_is_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[8])
        else $error("message end without run end");

    a_bare_marker_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("bare result that is not a clean end marker");

    a_byte_not_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tdata[9])
        else $error("data byte flagged as halted");

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);
